// ----- design/mexp_pkg.sv -----
// mexp_pkg: shared constants and types of the modular exponentiation block
// no dependencies; imported by mexp_mulmod and modular_exponentiation
package mexp_pkg;

   // widths of the external fields
   localparam int FIELD_W       = 32;
   localparam int DEFAULT_WIDTH = 32;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPONENT = 1'b1;

   // reset values of the configuration registers
   localparam logic [FIELD_W-1:0] MODULUS_RESET  = 32'd1;
   localparam logic [FIELD_W-1:0] EXPONENT_RESET = 32'd0;

   // status of the shared modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

// ----- design/modular_exponentiation.sv -----
// modular_exponentiation: top level, sequencer and configuration registers
// depends on mexp_pkg and mexp_mulmod
//
// Usage: each request on the req_ channel carries one base. The block returns
// base ^ exponent mod modulus on the rsp_ channel, one response per request.
// modulus and exponent are written through the csr_ port (index 0 modulus,
// index 1 exponent); the user must write them only while the block is idle,
// the block itself does not enforce this. A modulus of zero means 2^WIDTH.
// Work per request runs on one shared modular multiplier, with a decision step
// before each later product. A request needs one reduction product, then one
// square per exponent bit below the top set bit and one multiply per set bit:
// at most 2 * WIDTH products. The block handles one request at a time;
// req_ready is high only while idle.
// A finished result sits in an output register, so a new request may be taken
// while the previous response waits; if the receiver still stalls when the
// next result is ready, the sequencer holds it until the register frees up.
// Reset sets modulus to 1, exponent to 0 and empties the output register.
module modular_exponentiation import mexp_pkg::*; #(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FIELD_W-1:0]     req_base_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_W-1:0]     rsp_power_result,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_write_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REDUCE = 6'b000010,
      S_NEXT   = 6'b000100,
      S_MUL    = 6'b001000,
      S_SQR    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [FIELD_W-1:0] modulus_ff, modulus_in;
   logic [FIELD_W-1:0] exponent_ff, exponent_in;
   logic [WIDTH:0]   m_ff, m_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic             phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [WIDTH-1:0] mod_w;
   logic             mm_start;
   logic [WIDTH-1:0] mm_a, mm_b;
   logic [WIDTH-1:0] mm_product;
   mm_stat_type      mm_stat;
   logic             req_accept;
   logic             out_free;

   // configuration registers
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_write_data;
            CSR_EXPONENT: exponent_in = csr_write_data;
            default:      ;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign mod_w      = WIDTH'(modulus_ff);

   // sequencer: reduce the base, then multiply and square per exponent bit
   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mm_start     = 1'b0;
      mm_a         = base_ff;
      mm_b         = base_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               m_in     = (mod_w == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_w};
               e_in     = WIDTH'(exponent_ff);
               res_in   = WIDTH'(1);
               phase_in = 1'b0;
               // base mod m as 1 * base through the multiplier
               mm_start = 1'b1;
               mm_a     = WIDTH'(1);
               mm_b     = WIDTH'(req_base_value);
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (mm_stat.done) begin
               base_in  = mm_product;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            priority if (e_ff == '0) begin
               state_in = S_FINISH;
            end else if (e_ff[0] && !phase_ff) begin
               mm_start = 1'b1;
               mm_a     = res_ff;
               mm_b     = base_ff;
               state_in = S_MUL;
            end else if (e_ff[WIDTH-1:1] == '0) begin
               // no bits left, skip the last square
               e_in     = '0;
               state_in = S_FINISH;
            end else begin
               mm_start = 1'b1;
               state_in = S_SQR;
            end
         end
         S_MUL: begin
            if (mm_stat.done) begin
               res_in   = mm_product;
               phase_in = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_SQR: begin
            if (mm_stat.done) begin
               base_in  = mm_product;
               e_in     = {1'b0, e_ff[WIDTH-1:1]};
               phase_in = 1'b0;
               state_in = S_NEXT;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = FIELD_W'(res_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= MODULUS_RESET;
         exponent_ff  <= EXPONENT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      e_ff        <= e_in;
      base_ff     <= base_in;
      res_ff      <= res_in;
      phase_ff    <= phase_in;
      rsp_data_ff <= rsp_data_in;
   end

   mexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (state_ff == S_IDLE ? m_in : m_ff),
      .stat    (mm_stat),
      .product (mm_product)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

   // multiplier is never restarted while a product is in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_stat.busy)
      else $error("multiplier started while busy");

   // a finished product is only seen while the sequencer waits for one
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mm_stat.done |-> (state_ff == S_REDUCE || state_ff == S_MUL ||
                        state_ff == S_SQR))
      else $error("product finished outside a wait state");

   // the running base stays reduced below the modulus
   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> ({1'b0, base_ff} < m_ff))
      else $error("base not reduced");

   // after a multiply the partial result is reduced too
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT && phase_ff) |-> ({1'b0, res_ff} < m_ff))
      else $error("partial result not reduced");

endmodule

// ----- design/mexp_mulmod.sv -----
// mexp_mulmod: iterative modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg
module mexp_mulmod import mexp_pkg::*; #(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH:0]   modulus,
   output mm_stat_type      stat,
   output logic [WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(WIDTH);

   // (x + y) mod m for x, y below m; m of 2^WIDTH wraps
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH:0]   m);
      logic [WIDTH:0] gap;
      logic [WIDTH:0] sum;
      gap = m - {1'b0, y};
      if ({1'b0, x} >= gap) begin
         sum = {1'b0, x} - gap;
      end else begin
         sum = {1'b0, x} + {1'b0, y};
      end
      return sum[WIDTH-1:0];
   endfunction

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH:0]   m_ff, m_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] dbl;

   // one step: double, then add the multiplicand when the next bit is set
   always_comb begin
      dbl     = add_mod(acc_ff, acc_ff, m_ff);
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
         cnt_in  = CNT_W'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[WIDTH-1] ? add_mod(dbl, a_ff, m_ff) : dbl;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule
